/* rtl/core/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Command codes, special characters, payload structs, queue entry and the
// engine state encoding.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Fixed payload widths
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Special characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd0;

    // Configuration
    localparam int                APB_ADDR_W     = 3;
    localparam logic              REG_TEXT_COLOR = 1'b0;
    localparam logic [CHAR_W-1:0] COLOR_RESET    = 8'd15;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CHAR_W-1:0] read_char;
        logic [CHAR_W-1:0] read_attr;
    } out_item_t;

    // Classified operation
    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
    } job_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_ZERO,
        ST_CLEAR,
        ST_FINISH
    } state_t;

endpackage

/* rtl/core/tcw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front: command intake
// Accepts input transactions and classifies them into queue jobs.
// ----------------------------------------------------------------------------
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  tcw_pkg::in_item_t s_item,
    input  logic              queue_full,
    input  logic              init_busy,
    output logic              push,
    output tcw_pkg::job_t     push_job
);

    localparam int CELLS = COLUMNS * ROWS;

    assign s_ready = !queue_full && !init_busy;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_job.ch  = s_item.char_code;
        push_job.idx = s_item.cell_index;
        case (s_item.cmd)
            tcw_pkg::CMD_PUT: begin
                if (s_item.char_code == tcw_pkg::CH_NEWLINE) begin
                    push_job.op = tcw_pkg::OP_NEWLINE;
                end else if (s_item.char_code == tcw_pkg::CH_BACKSPACE) begin
                    push_job.op = tcw_pkg::OP_BACKSPACE;
                end else begin
                    push_job.op = tcw_pkg::OP_PUT;
                end
            end
            tcw_pkg::CMD_CLEAR: begin
                push_job.op = tcw_pkg::OP_CLEAR;
            end
            tcw_pkg::CMD_READ: begin
                // out-of-range reads answer zero without touching the store
                if (32'(s_item.cell_index) < 32'(CELLS)) begin
                    push_job.op = tcw_pkg::OP_READ;
                end else begin
                    push_job.op = tcw_pkg::OP_NOP;
                end
            end
            default: begin
                push_job.op = tcw_pkg::OP_NOP;
            end
        endcase
    end

endmodule

/* rtl/core/tcw_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue: job queue
// Two-entry register queue between the intake and the engine.
// ----------------------------------------------------------------------------
module tcw_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tcw_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output tcw_pkg::job_t head_job
);

    tcw_pkg::job_t                     entry_reg [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tcw_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tcw_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;

    assign full       = count_reg == tcw_pkg::QUEUE_CNT_W'(tcw_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/core/tcw_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_engine: console engine
// Owns the cell store and cursor, runs jobs, sweeps for scroll and clear.
// ----------------------------------------------------------------------------
module tcw_engine #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [tcw_pkg::CHAR_W-1:0]  text_color,
    input  logic                        job_valid,
    input  tcw_pkg::job_t               job,
    output logic                        job_pop,
    output logic                        init_busy,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tcw_pkg::out_item_t          m_item
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

    logic [tcw_pkg::CHAR_W-1:0] char_mem [CELLS];
    logic [tcw_pkg::CHAR_W-1:0] attr_mem [CELLS];

    tcw_pkg::state_t            state_reg, state_next;
    logic [ADDR_W-1:0]          cnt_reg, cnt_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    tcw_pkg::job_t              job_reg;
    logic                       copy_valid_reg, copy_valid_next;
    logic [ADDR_W-1:0]          copy_addr_reg, copy_addr_next;
    logic [tcw_pkg::CHAR_W-1:0] rd_char_reg, rd_attr_reg;
    logic                       m_valid_reg;
    tcw_pkg::out_item_t         m_item_reg;

    logic                       out_free;
    logic [ADDR_W-1:0]          here, pos_next, bs_addr, rd_addr;
    logic                       wr_en, wr_attr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [tcw_pkg::CHAR_W-1:0] wr_char, wr_attr;
    logic                       load_result;
    logic [tcw_pkg::CHAR_W-1:0] res_char, res_attr;

    assign out_free  = !m_valid_reg || m_ready;
    assign here      = ADDR_W'(row_reg) * ROW_SPAN + ADDR_W'(col_reg);
    assign pos_next  = ADDR_W'(row_next) * ROW_SPAN + ADDR_W'(col_next);
    assign bs_addr   = here - ((col_reg != '0) ? ADDR_W'(1) : '0);
    assign job_pop   = (state_reg == tcw_pkg::ST_IDLE) && job_valid;
    assign init_busy = state_reg == tcw_pkg::ST_INIT;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_INIT: begin
                if (cnt_reg == LAST_CELL) state_next = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_IDLE: begin
                if (job_valid) state_next = tcw_pkg::ST_EXEC;
            end
            tcw_pkg::ST_EXEC: begin
                if (out_free) begin
                    case (job_reg.op)
                        tcw_pkg::OP_PUT: begin
                            if (col_reg == LAST_COL && row_reg == LAST_ROW) begin
                                state_next = tcw_pkg::ST_SCROLL;
                            end else begin
                                state_next = tcw_pkg::ST_IDLE;
                            end
                        end
                        tcw_pkg::OP_NEWLINE: begin
                            if (row_reg == LAST_ROW) begin
                                state_next = tcw_pkg::ST_SCROLL;
                            end else begin
                                state_next = tcw_pkg::ST_IDLE;
                            end
                        end
                        tcw_pkg::OP_CLEAR: state_next = tcw_pkg::ST_CLEAR;
                        tcw_pkg::OP_READ:  state_next = tcw_pkg::ST_READ;
                        default:           state_next = tcw_pkg::ST_IDLE;
                    endcase
                end
            end
            tcw_pkg::ST_READ: begin
                if (out_free) state_next = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_SCROLL: begin
                if (cnt_reg == COPY_LAST) state_next = tcw_pkg::ST_ZERO;
            end
            tcw_pkg::ST_ZERO: begin
                if (!copy_valid_reg && cnt_reg == LAST_CELL) state_next = tcw_pkg::ST_FINISH;
            end
            tcw_pkg::ST_CLEAR: begin
                if (cnt_reg == LAST_CELL) state_next = tcw_pkg::ST_FINISH;
            end
            tcw_pkg::ST_FINISH: begin
                if (out_free) state_next = tcw_pkg::ST_IDLE;
            end
            default: begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb begin
        cnt_next        = cnt_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        copy_valid_next = 1'b0;
        copy_addr_next  = copy_addr_reg;
        rd_addr         = ADDR_W'(job_reg.idx);
        wr_en           = 1'b0;
        wr_attr_en      = 1'b0;
        wr_addr         = cnt_reg;
        wr_char         = tcw_pkg::CH_BLANK;
        wr_attr         = '0;
        load_result     = 1'b0;
        res_char        = '0;
        res_attr        = '0;
        case (state_reg)
            tcw_pkg::ST_INIT: begin
                wr_en      = 1'b1;
                wr_attr_en = 1'b1;
                cnt_next   = (cnt_reg == LAST_CELL) ? '0 : cnt_reg + 1'b1;
            end
            tcw_pkg::ST_EXEC: begin
                if (out_free) begin
                    case (job_reg.op)
                        tcw_pkg::OP_PUT: begin
                            wr_en      = 1'b1;
                            wr_attr_en = 1'b1;
                            wr_addr    = here;
                            wr_char    = job_reg.ch;
                            wr_attr    = text_color;
                            if (col_reg == LAST_COL) begin
                                col_next = '0;
                                if (row_reg == LAST_ROW) begin
                                    cnt_next = '0;
                                end else begin
                                    row_next    = row_reg + 1'b1;
                                    load_result = 1'b1;
                                end
                            end else begin
                                col_next    = col_reg + 1'b1;
                                load_result = 1'b1;
                            end
                        end
                        tcw_pkg::OP_NEWLINE: begin
                            col_next = '0;
                            if (row_reg == LAST_ROW) begin
                                cnt_next = '0;
                            end else begin
                                row_next    = row_reg + 1'b1;
                                load_result = 1'b1;
                            end
                        end
                        tcw_pkg::OP_BACKSPACE: begin
                            // blank the character, keep the attribute
                            wr_en       = 1'b1;
                            wr_addr     = bs_addr;
                            col_next    = (col_reg != '0) ? col_reg - 1'b1 : '0;
                            load_result = 1'b1;
                        end
                        tcw_pkg::OP_CLEAR: begin
                            col_next = '0;
                            row_next = '0;
                            cnt_next = '0;
                        end
                        tcw_pkg::OP_READ: begin
                            rd_addr = ADDR_W'(job_reg.idx);
                        end
                        default: begin
                            load_result = 1'b1;
                        end
                    endcase
                end
            end
            tcw_pkg::ST_READ: begin
                if (out_free) begin
                    load_result = 1'b1;
                    res_char    = rd_char_reg;
                    res_attr    = rd_attr_reg;
                end
            end
            tcw_pkg::ST_SCROLL: begin
                // read one row down and write the registered data back one row up
                rd_addr         = cnt_reg + ROW_SPAN;
                copy_valid_next = 1'b1;
                copy_addr_next  = cnt_reg;
                cnt_next        = cnt_reg + 1'b1;
            end
            tcw_pkg::ST_ZERO: begin
                if (!copy_valid_reg) begin
                    wr_en      = 1'b1;
                    wr_attr_en = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            tcw_pkg::ST_CLEAR: begin
                wr_en      = 1'b1;
                wr_attr_en = 1'b1;
                wr_attr    = text_color;
                cnt_next   = cnt_reg + 1'b1;
            end
            tcw_pkg::ST_FINISH: begin
                load_result = out_free;
            end
            default: begin
                load_result = 1'b0;
            end
        endcase
        // drain the pending scroll copy
        if (copy_valid_reg) begin
            wr_en      = 1'b1;
            wr_attr_en = 1'b1;
            wr_addr    = copy_addr_reg;
            wr_char    = rd_char_reg;
            wr_attr    = rd_attr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tcw_pkg::ST_INIT;
            cnt_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            copy_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            copy_valid_reg <= copy_valid_next;
            if (load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        copy_addr_reg <= copy_addr_next;
        if (job_pop) begin
            job_reg <= job;
        end
        if (load_result) begin
            m_item_reg.cursor_pos <= tcw_pkg::pos_t'(pos_next);
            m_item_reg.read_char  <= res_char;
            m_item_reg.read_attr  <= res_attr;
        end
    end

    // cell store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            char_mem[wr_addr] <= wr_char;
            if (wr_attr_en) begin
                attr_mem[wr_addr] <= wr_attr;
            end
        end
        rd_char_reg <= char_mem[rd_addr];
        rd_attr_reg <= attr_mem[rd_addr];
    end

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= LAST_COL)
        else $error("cursor column beyond row end");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= LAST_ROW)
        else $error("cursor row beyond last row");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_result && m_valid_reg) |-> m_ready)
        else $error("result register overwritten while held");

    a_copy_window: assert property (@(posedge aclk) disable iff (!aresetn)
        copy_valid_reg |-> (state_reg == tcw_pkg::ST_SCROLL || state_reg == tcw_pkg::ST_ZERO))
        else $error("scroll copy pending outside scroll");

endmodule

/* rtl/core/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console over a COLUMNS x ROWS cell store
//
// Input channel (s_valid/s_ready/s_item) carries one command per transaction:
// put character (newline and backspace included), clear screen, or read cell.
// Result channel (m_valid/m_ready/m_item) returns exactly one transaction per
// command: the cursor position after the command, plus the cell on a read.
// The APB port holds text_color at byte address 0; writes take effect on the
// access cycle and should only be issued while the block is idle.
// With the engine idle, a plain put, newline or backspace loads its result
// from the execute state and a read from the read state, after the registered
// store read; the engine takes a new job only once the last one is done. A
// put or newline that scrolls copies each row up (one cell copied per cycle),
// then zeroes the last row and shows its result; a clear first writes every
// cell. The single write port of the cell store paces both sweeps.
// After reset the engine zeroes all COLUMNS*ROWS cells (2000 at 80x25), one
// cell per cycle; s_ready stays low during that pass.
// A stalled receiver holds the result register; the two-entry job queue
// keeps accepting until it fills, then s_ready drops.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // command channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tcw_pkg::in_item_t               s_item,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output tcw_pkg::out_item_t              m_item,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [tcw_pkg::CHAR_W-1:0] color_reg;
    logic                       color_sel;

    logic                       queue_full;
    logic                       init_busy;
    logic                       push;
    tcw_pkg::job_t              push_job;
    logic                       pop;
    logic                       head_valid;
    tcw_pkg::job_t              head_job;

    // Decode the word index; the port is always ready
    assign color_sel = paddr[2] == tcw_pkg::REG_TEXT_COLOR;
    assign pready    = 1'b1;
    assign prdata    = color_sel ? {24'd0, color_reg} : 32'd0;

    // Write text_color on the APB access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= tcw_pkg::COLOR_RESET;
        end else if (psel && penable && pwrite && color_sel) begin
            color_reg <= pwdata[tcw_pkg::CHAR_W-1:0];
        end
    end

    // Front: accept and classify each command transaction
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .queue_full (queue_full),
        .init_busy  (init_busy),
        .push       (push),
        .push_job   (push_job)
    );

    // Queue: decouple intake from the engine
    tcw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back: carry out jobs against the cell store and drive results
    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .text_color (color_reg),
        .job_valid  (head_valid),
        .job        (head_job),
        .job_pop    (pop),
        .init_busy  (init_busy),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

/* sim/console_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_checker: result checker for the text console writer
// Mirrors the cell store, the cursor and the text color from the command and
// APB traffic it observes, predicts the result of every accepted command and
// compares each result transaction, field by field, against the oldest
// prediction. Also checks text_color readback on the APB port.
// ----------------------------------------------------------------------------
module console_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  tcw_pkg::in_item_t               s_item,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  tcw_pkg::out_item_t              m_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    input  logic [31:0]                     prdata,
    output int                              outstanding,
    output int                              error_count
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam logic [APB_ADDR_W-1:0] COLOR_ADDR = APB_ADDR_W'(4 * REG_TEXT_COLOR);

    // cell layout: attribute in the upper byte, character in the lower byte
    logic [15:0]       screen [CELLS];
    int                cur_col;
    int                cur_row;
    logic [CHAR_W-1:0] text_color;
    out_item_t         expected_results [$];

    initial begin
        outstanding = 0;
        error_count = 0;
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t ns console_checker: %s: expected %0d, got %0d",
                 $realtime, what, want, got);
        error_count++;
    endtask

    task automatic reset_console();
        for (int i = 0; i < CELLS; i++) screen[i] = '0;
        cur_col    = 0;
        cur_row    = 0;
        text_color = COLOR_RESET;
    endtask

    function automatic int cursor_cell();
        return cur_row * COLUMNS + cur_col;
    endfunction

    // step down one row; past the bottom, shift everything up and blank the last row
    task automatic advance_row();
        cur_row++;
        if (cur_row >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = '0;
            cur_row = ROWS - 1;
        end
    endtask

    task automatic predict_console_step(input in_item_t cmd_in, output out_item_t res);
        int spot;
        res = '0;
        case (cmd_in.cmd)
            CMD_PUT: begin
                if (cmd_in.char_code == CH_NEWLINE) begin
                    cur_col = 0;
                    advance_row();
                end else if (cmd_in.char_code == CH_BACKSPACE) begin
                    // held at column 0; the attribute byte survives
                    if (cur_col > 0) cur_col--;
                    spot = cursor_cell();
                    screen[spot][CHAR_W-1:0] = CH_BLANK;
                end else begin
                    screen[cursor_cell()] = {text_color, cmd_in.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        advance_row();
                    end
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen[i] = {text_color, CH_BLANK};
                cur_col = 0;
                cur_row = 0;
            end
            CMD_READ: begin
                if (int'(cmd_in.cell_index) < CELLS) begin
                    res.read_char = screen[cmd_in.cell_index][CHAR_W-1:0];
                    res.read_attr = screen[cmd_in.cell_index][15:CHAR_W];
                end
            end
            default: ;
        endcase
        res.cursor_pos = POS_W'(cursor_cell());
    endtask

    always @(posedge aclk) begin : monitor
        out_item_t want;
        out_item_t got;
        if (!aresetn) begin
            reset_console();
            expected_results.delete();
            outstanding = 0;
        end else begin
            if (psel && penable && pready && paddr == COLOR_ADDR) begin
                if (pwrite) begin
                    text_color = pwdata[CHAR_W-1:0];
                end else if (prdata !== {24'd0, text_color}) begin
                    report_mismatch("text_color readback", 32'(text_color), prdata);
                end
            end
            if (m_valid && m_ready) begin
                got = m_item;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none pending, cursor_pos", 0,
                                    32'(got.cursor_pos));
                end else begin
                    want = expected_results.pop_front();
                    if (got.cursor_pos !== want.cursor_pos)
                        report_mismatch("cursor_pos", 32'(want.cursor_pos),
                                        32'(got.cursor_pos));
                    if (got.read_char !== want.read_char)
                        report_mismatch("read_char", 32'(want.read_char),
                                        32'(got.read_char));
                    if (got.read_attr !== want.read_attr)
                        report_mismatch("read_attr", 32'(want.read_attr),
                                        32'(got.read_attr));
                end
            end
            if (s_valid && s_ready) begin
                predict_console_step(s_item, want);
                expected_results.push_back(want);
            end
            outstanding = expected_results.size();
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: text console writer, directed and random command streams
// Drives put, clear and read commands plus the unused code through the
// command channel, with random gaps on both channels, and sweeps text_color
// over the APB port between phases. The console_checker instance predicts
// and checks every result; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import tcw_pkg::*;

    localparam int COLUMNS         = COLUMNS_DEF;
    localparam int ROWS            = ROWS_DEF;
    localparam int CELLS           = COLUMNS * ROWS;
    // a scroll or a clear walks the whole store; leave margin past that
    localparam int SETTLE_CYCLES   = CELLS + 16;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 172;
    localparam int MAX_GAP         = 8;
    localparam logic [CMD_W-1:0]      CMD_UNUSED = 2'd3;
    localparam logic [IDX_W-1:0]      IDX_MAX    = '1;
    localparam logic [APB_ADDR_W-1:0] COLOR_ADDR = APB_ADDR_W'(4 * REG_TEXT_COLOR);

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_item  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_item;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int outstanding;
    int error_count;
    int quiet_cycles = 0;
    int ready_hold   = 0;
    int ready_draw;
    int text_run     = 0;
    bit sink_eager   = 1'b0;
    bit source_eager = 1'b0;

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    console_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) console_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .outstanding (outstanding),
        .error_count (error_count)
    );

    // Result side: after each transaction (and once out of reset) draw how
    // long to hold m_ready low before taking the next result. Zero keeps
    // m_ready high, so back-to-back results pass untouched.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= (ready_hold == 1);
        end else if (!m_ready || m_valid) begin
            ready_draw = sink_eager ? 0 : $urandom_range(0, MAX_GAP);
            m_ready    <= (ready_draw == 0);
            ready_hold <= ready_draw;
        end
    end

    // Watchdog: count cycles in which no transaction moves on either channel
    // and no APB access completes; give up once the count hits the limit.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Offer one command after a random gap and hold it until accepted.
    // Call at a rising edge; returns at the edge of acceptance.
    task automatic send_command(input in_item_t cmd_in);
        int gap;
        gap = source_eager ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= cmd_in;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic put_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                               input logic [IDX_W-1:0] idx);
        in_item_t cmd_in;
        cmd_in.cmd        = cmd;
        cmd_in.char_code  = ch;
        cmd_in.cell_index = idx;
        send_command(cmd_in);
    endtask

    // Drop valid, wait until every result is back, then let a full scroll
    // or clear finish inside the block before touching the register.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One APB transfer to text_color: setup, access, then idle with psel low so
    // the next transfer starts in a fresh time step.
    task automatic apb_access(input bit write, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= COLOR_ADDR;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Random command mix. Mostly text with newlines and backspaces; now and
    // then a long run of plain characters so rows wrap and the store scrolls.
    // Reads lean on the bottom rows, where the scrolled text sits.
    task automatic pick_command(output in_item_t cmd_in);
        int sel;
        cmd_in.cmd        = CMD_PUT;
        cmd_in.char_code  = CHAR_W'($urandom_range(0, 255));
        cmd_in.cell_index = IDX_W'($urandom_range(0, 2047));
        if (text_run > 0) begin
            text_run--;
            if (cmd_in.char_code == CH_NEWLINE || cmd_in.char_code == CH_BACKSPACE)
                cmd_in.char_code = 8'h20;
        end else begin
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                // plain character as drawn
            end else if (sel < 60) begin
                cmd_in.char_code = CH_NEWLINE;
            end else if (sel < 68) begin
                cmd_in.char_code = CH_BACKSPACE;
            end else if (sel < 72) begin
                text_run = $urandom_range(60, 160);
            end else if (sel < 90) begin
                cmd_in.cmd = CMD_READ;
                if (sel >= 81)
                    cmd_in.cell_index = IDX_W'($urandom_range(CELLS - 6 * COLUMNS, CELLS - 1));
            end else if (sel < 93) begin
                cmd_in.cmd = CMD_UNUSED;
            end else begin
                cmd_in.cmd = CMD_CLEAR;
            end
        end
    endtask

    initial begin : stimulus
        in_item_t          cmd_in;
        logic [CHAR_W-1:0] color;

        // Hold reset low, then release it for good
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Read back the reset color while the store clears itself
        apb_access(1'b0, '0);

        // Directed part, reset color: field extremes, each command, and the
        // corner cases of backspace and of reads outside the store
        put_command(CMD_PUT, 8'h41, '0);
        put_command(CMD_PUT, 8'h00, IDX_MAX);
        put_command(CMD_PUT, 8'hFF, '0);
        put_command(CMD_PUT, CH_BACKSPACE, '0);          // step back, blank the char
        put_command(CMD_READ, 8'hFF, 11'd2);             // attribute kept, char blank
        put_command(CMD_READ, 8'h00, 11'd1);
        put_command(CMD_PUT, CH_NEWLINE, '0);
        put_command(CMD_PUT, CH_BACKSPACE, IDX_MAX);     // backspace at column 0
        put_command(CMD_READ, 8'h00, IDX_W'(COLUMNS));   // cell only blanked by the backspace
        put_command(CMD_READ, 8'h00, '0);
        put_command(CMD_READ, 8'h00, IDX_W'(CELLS - 1));
        put_command(CMD_READ, 8'h00, IDX_W'(CELLS));     // just past the store
        put_command(CMD_READ, 8'h00, IDX_MAX);
        put_command(CMD_UNUSED, 8'hFF, IDX_MAX);         // ignored command
        put_command(CMD_UNUSED, 8'h00, '0);
        put_command(CMD_CLEAR, 8'hFF, IDX_MAX);
        put_command(CMD_READ, 8'h00, IDX_W'(CELLS - 1)); // blank in reset color
        put_command(CMD_PUT, CH_BACKSPACE, '0);          // backspace at home
        put_command(CMD_PUT, 8'h55, IDX_MAX);
        put_command(CMD_READ, 8'hFF, '0);

        // Random phases, each under its own text color; both extremes first
        for (int phase = 0; phase < PHASES; phase++) begin
            // Drain first: the register only changes while the block is idle
            wait_for_results();
            case (phase)
                0:       color = 8'h00;
                1:       color = 8'hFF;
                3:       color = 8'h80;
                default: color = CHAR_W'($urandom_range(0, 255));
            endcase
            apb_access(1'b1, {24'd0, color});
            apb_access(1'b0, '0);

            source_eager = ($urandom_range(0, 3) == 0);
            sink_eager  <= ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Redraw the idling style now and then so stretches without
                // gaps alternate with gappy ones
                if (n % 50 == 49) begin
                    source_eager = ($urandom_range(0, 3) == 0);
                    sink_eager  <= ($urandom_range(0, 3) == 0);
                end
                pick_command(cmd_in);
                send_command(cmd_in);
            end
        end

        // Wait out the last results and any scroll still running, then judge
        wait_for_results();
        @(negedge aclk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

/* files.f */
rtl/core/tcw_pkg.sv
rtl/core/tcw_front.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_engine.sv
rtl/core/text_console_writer.sv
sim/console_checker.sv
sim/testbench.sv
